// ----- rtl/fud_pkg.sv -----
// ============================================================================
// fud_pkg
// Shared types and constants of the fisheye undistortion coordinate mapper.
// ============================================================================
package fud_pkg;

    // Stage counts of the iterative units
    localparam int SQRT_STEPS   = 24;
    localparam int CORDIC_STEPS = 24;
    localparam int DIV_STEPS    = 26;

    // Radius below which the scale is exactly one (Q.20)
    localparam int R_MIN_Q20 = 2;

    // Request carried on the input channel
    typedef struct packed {
        logic [11:0] out_x;
        logic [11:0] out_y;
    } in_req_t;

    // Request carried on the output channel
    typedef struct packed {
        logic signed [15:0] src_x;
        logic signed [15:0] src_y;
        logic               in_range;
    } out_req_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_FOCAL_X     = 3'd0,
        REG_FOCAL_Y     = 3'd1,
        REG_CENTRE_X    = 3'd2,
        REG_CENTRE_Y    = 3'd3,
        REG_INV_FOCAL_X = 3'd4,
        REG_INV_FOCAL_Y = 3'd5,
        REG_DIST_K1_K2  = 3'd6,
        REG_DIST_K3_K4  = 3'd7
    } reg_idx_t;

    // atan(2^-i) in Q.20, rounded to nearest
    function automatic logic [20:0] atan_q20(input int unsigned i);
        logic [20:0] v;
        case (i)
            0:       v = 21'd823550;
            1:       v = 21'd486170;
            2:       v = 21'd256879;
            3:       v = 21'd130396;
            4:       v = 21'd65451;
            5:       v = 21'd32757;
            6:       v = 21'd16383;
            7:       v = 21'd8192;
            8:       v = 21'd4096;
            9:       v = 21'd2048;
            10:      v = 21'd1024;
            11:      v = 21'd512;
            12:      v = 21'd256;
            13:      v = 21'd128;
            14:      v = 21'd64;
            15:      v = 21'd32;
            16:      v = 21'd16;
            17:      v = 21'd8;
            18:      v = 21'd4;
            19:      v = 21'd2;
            20:      v = 21'd1;
            21:      v = 21'd1;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/fud_isqrt.sv -----
// ============================================================================
// fud_isqrt
// Pipelined integer square root of a 48-bit radicand, one result bit a stage.
// ============================================================================
module fud_isqrt #(
    parameter int SIDE_W = 48
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [47:0]       radicand,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [23:0]       root,
    output logic [SIDE_W-1:0] side_out
);

    localparam int STEPS = fud_pkg::SQRT_STEPS;

    logic [47:0]       n_reg    [STEPS];
    logic [47:0]       res_reg  [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];
    logic              v_reg    [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        localparam logic [47:0] BIT = 48'(1) << (2 * (STEPS - 1 - k));

        logic [47:0]       n_cur;
        logic [47:0]       res_cur;
        logic [SIDE_W-1:0] side_cur;
        logic              v_cur;
        logic [48:0]       trial;
        logic [47:0]       n_next;
        logic [47:0]       res_next;

        if (k == 0) begin : g_first
            assign n_cur    = radicand;
            assign res_cur  = '0;
            assign side_cur = side_in;
            assign v_cur    = in_valid;
        end else begin : g_rest
            assign n_cur    = n_reg[k-1];
            assign res_cur  = res_reg[k-1];
            assign side_cur = side_reg[k-1];
            assign v_cur    = v_reg[k-1];
        end

        // Try the next root bit; keep it when the remainder allows
        always_comb
        begin
            trial = {1'b0, res_cur} + {1'b0, BIT};
            if ({1'b0, n_cur} >= trial)
            begin
                n_next   = n_cur - trial[47:0];
                res_next = (res_cur >> 1) + BIT;
            end
            else
            begin
                n_next   = n_cur;
                res_next = res_cur >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k]    <= n_next;
                res_reg[k]  <= res_next;
                side_reg[k] <= side_cur;
            end
        end
    end

    assign out_valid = v_reg[STEPS-1];
    assign root      = res_reg[STEPS-1][23:0];
    assign side_out  = side_reg[STEPS-1];

endmodule

// ----- rtl/fud_div.sv -----
// ============================================================================
// fud_div
// Pipelined restoring divider: 56-bit dividend by 24-bit divisor, 26 quotient
// bits, one bit a stage.
// ============================================================================
module fud_div #(
    parameter int SIDE_W = 49
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [55:0]       dividend,
    input  logic [23:0]       divisor,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [25:0]       quotient,
    output logic [SIDE_W-1:0] side_out
);

    localparam int STEPS = fud_pkg::DIV_STEPS;

    logic [55:0]       rem_reg  [STEPS];
    logic [23:0]       d_reg    [STEPS];
    logic [25:0]       q_reg    [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];
    logic              v_reg    [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        localparam int SH = STEPS - 1 - k;

        logic [55:0]       rem_cur;
        logic [23:0]       d_cur;
        logic [25:0]       q_cur;
        logic [SIDE_W-1:0] side_cur;
        logic              v_cur;
        logic [55:0]       d_sh;
        logic [55:0]       rem_next;
        logic [25:0]       q_next;

        if (k == 0) begin : g_first
            assign rem_cur  = dividend;
            assign d_cur    = divisor;
            assign q_cur    = '0;
            assign side_cur = side_in;
            assign v_cur    = in_valid;
        end else begin : g_rest
            assign rem_cur  = rem_reg[k-1];
            assign d_cur    = d_reg[k-1];
            assign q_cur    = q_reg[k-1];
            assign side_cur = side_reg[k-1];
            assign v_cur    = v_reg[k-1];
        end

        // Subtract the shifted divisor when it fits
        always_comb
        begin
            d_sh = 56'(d_cur) << SH;
            if (rem_cur >= d_sh)
            begin
                rem_next = rem_cur - d_sh;
                q_next   = q_cur | (26'(1) << SH);
            end
            else
            begin
                rem_next = rem_cur;
                q_next   = q_cur;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                d_reg[k]    <= d_cur;
                q_reg[k]    <= q_next;
                side_reg[k] <= side_cur;
            end
        end
    end

    assign out_valid = v_reg[STEPS-1];
    assign quotient  = q_reg[STEPS-1];
    assign side_out  = side_reg[STEPS-1];

    // Remainder ends below the divisor (quotient did not overflow)
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[STEPS-1] && d_reg[STEPS-1] >= 24'd2)
            |-> (rem_reg[STEPS-1] < 56'(d_reg[STEPS-1])))
        else $error("divider remainder not below divisor");

endmodule

// ----- rtl/fisheye_undistort_map.sv -----
// ============================================================================
// fisheye_undistort_map
// Maps an output pixel to its fisheye source pixel: back-projection, radius,
// atan by CORDIC, distortion polynomial, scale division and reprojection.
// ============================================================================
//
//  Channel  Handshake             Payload                  Role
//  in       in_valid / in_ready   in_data  (in_req_t)      output pixel
//  out      out_valid / out_ready out_data (out_req_t)     source pixel
//  cfg      cfg_write             cfg_index, cfg_data      register write
//
//  One request enters per cycle unless the output stalls; the pipeline has 4 front
//  stages, 24 square-root stages, 24 CORDIC stages, 8 polynomial stages, 26 divider
//  stages and 3 reprojection stages.
//  All stages advance together; a request waiting at the output stalls the
//  whole pipeline and in_ready drops in the same cycle.
//  Reset clears the valid bits and the configuration registers.
//
module fisheye_undistort_map #(
    parameter int IMG_WIDTH  = 1024,
    parameter int IMG_HEIGHT = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fud_pkg::in_req_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output fud_pkg::out_req_t  out_data,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int CSTEPS = fud_pkg::CORDIC_STEPS;
    localparam logic [20:0] TH_MAX = 21'd1827970;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [19:0] focal_x_reg, focal_y_reg, centre_x_reg, centre_y_reg;
    logic [23:0] inv_x_reg, inv_y_reg;
    logic [31:0] k12_reg, k34_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= '0;
            focal_y_reg  <= '0;
            centre_x_reg <= '0;
            centre_y_reg <= '0;
            inv_x_reg    <= '0;
            inv_y_reg    <= '0;
            k12_reg      <= '0;
            k34_reg      <= '0;
        end
        else if (cfg_write)
        begin
            case (fud_pkg::reg_idx_t'(cfg_index))
                fud_pkg::REG_FOCAL_X:     focal_x_reg  <= cfg_data[19:0];
                fud_pkg::REG_FOCAL_Y:     focal_y_reg  <= cfg_data[19:0];
                fud_pkg::REG_CENTRE_X:    centre_x_reg <= cfg_data[19:0];
                fud_pkg::REG_CENTRE_Y:    centre_y_reg <= cfg_data[19:0];
                fud_pkg::REG_INV_FOCAL_X: inv_x_reg    <= cfg_data[23:0];
                fud_pkg::REG_INV_FOCAL_Y: inv_y_reg    <= cfg_data[23:0];
                fud_pkg::REG_DIST_K1_K2:  k12_reg      <= cfg_data;
                fud_pkg::REG_DIST_K3_K4:  k34_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Global advance: move every stage unless the output request waits
    // ------------------------------------------------------------------
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    function automatic logic signed [23:0] sat24(input logic signed [46:0] v);
        if (v > 47'sd8388607)
            return 24'sd8388607;
        else if (v < -47'sd8388608)
            return -24'sd8388608;
        else
            return v[23:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [24:0] v);
        if (v > 25'sd32767)
            return 16'sd32767;
        else if (v < -25'sd32768)
            return -16'sd32768;
        else
            return v[15:0];
    endfunction

    // ------------------------------------------------------------------
    // S1: offset from centre times reciprocal focal length
    // ------------------------------------------------------------------
    logic               s1_v_reg;
    logic signed [46:0] s1_px_reg, s1_py_reg;
    logic signed [21:0] dx, dy;

    assign dx = $signed({2'b0, in_data.out_x, 8'd0}) - $signed({2'b0, centre_x_reg});
    assign dy = $signed({2'b0, in_data.out_y, 8'd0}) - $signed({2'b0, centre_y_reg});

    // S2: floor shift and saturate to Q4.20
    logic               s2_v_reg;
    logic signed [23:0] s2_a_reg, s2_b_reg;

    // S3: squares
    logic               s3_v_reg;
    logic signed [23:0] s3_a_reg, s3_b_reg;
    logic signed [47:0] s3_asq_reg, s3_bsq_reg;

    // S4: sum of squares
    logic               s4_v_reg;
    logic signed [23:0] s4_a_reg, s4_b_reg;
    logic [47:0]        s4_n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_px_reg  <= 47'(dx) * 47'($signed({1'b0, inv_x_reg}));
            s1_py_reg  <= 47'(dy) * 47'($signed({1'b0, inv_y_reg}));
            s2_a_reg   <= sat24(s1_px_reg >>> 12);
            s2_b_reg   <= sat24(s1_py_reg >>> 12);
            s3_a_reg   <= s2_a_reg;
            s3_b_reg   <= s2_b_reg;
            s3_asq_reg <= 48'(s2_a_reg) * 48'(s2_a_reg);
            s3_bsq_reg <= 48'(s2_b_reg) * 48'(s2_b_reg);
            s4_a_reg   <= s3_a_reg;
            s4_b_reg   <= s3_b_reg;
            s4_n_reg   <= 48'(s3_asq_reg) + 48'(s3_bsq_reg);
        end
    end

    // ------------------------------------------------------------------
    // Radius
    // ------------------------------------------------------------------
    logic        sq_v;
    logic [23:0] sq_r;
    logic [47:0] sq_side;

    fud_isqrt #(
        .SIDE_W (48)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_v_reg),
        .radicand  (s4_n_reg),
        .side_in   ({s4_a_reg, s4_b_reg}),
        .out_valid (sq_v),
        .root      (sq_r),
        .side_out  (sq_side)
    );

    // ------------------------------------------------------------------
    // Theta = atan(r), CORDIC vectoring, one iteration a stage
    // ------------------------------------------------------------------
    logic signed [35:0] cx_reg [CSTEPS];
    logic signed [35:0] cy_reg [CSTEPS];
    logic signed [23:0] cz_reg [CSTEPS];
    logic [47:0]        cab_reg [CSTEPS];
    logic [23:0]        cr_reg [CSTEPS];
    logic               cv_reg [CSTEPS];

    for (genvar k = 0; k < CSTEPS; k++) begin : g_cordic
        localparam logic signed [23:0] ATAN = $signed({3'b0, fud_pkg::atan_q20(k)});

        logic signed [35:0] x_cur, y_cur, x_next, y_next;
        logic signed [23:0] z_cur, z_next;
        logic [47:0]        ab_cur;
        logic [23:0]        r_cur;
        logic               v_cur;

        if (k == 0) begin : g_first
            assign x_cur  = 36'sd268435456;
            assign y_cur  = $signed({4'b0, sq_r, 8'd0});
            assign z_cur  = '0;
            assign ab_cur = sq_side;
            assign r_cur  = sq_r;
            assign v_cur  = sq_v;
        end else begin : g_rest
            assign x_cur  = cx_reg[k-1];
            assign y_cur  = cy_reg[k-1];
            assign z_cur  = cz_reg[k-1];
            assign ab_cur = cab_reg[k-1];
            assign r_cur  = cr_reg[k-1];
            assign v_cur  = cv_reg[k-1];
        end

        // Rotate toward the x axis by the sign of y
        always_comb
        begin
            if (y_cur > 36'sd0)
            begin
                x_next = x_cur + (y_cur >>> k);
                y_next = y_cur - (x_cur >>> k);
                z_next = z_cur + ATAN;
            end
            else
            begin
                x_next = x_cur - (y_cur >>> k);
                y_next = y_cur + (x_cur >>> k);
                z_next = z_cur - ATAN;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[k] <= 1'b0;
            else if (en)
                cv_reg[k] <= v_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cx_reg[k]  <= x_next;
                cy_reg[k]  <= y_next;
                cz_reg[k]  <= z_next;
                cab_reg[k] <= ab_cur;
                cr_reg[k]  <= r_cur;
            end
        end
    end

    // ------------------------------------------------------------------
    // Distortion polynomial and theta_d
    // ------------------------------------------------------------------
    logic signed [23:0] z_end;
    logic [20:0]        th;
    logic signed [15:0] k1, k2, k3, k4;

    assign z_end = cz_reg[CSTEPS-1];
    assign th    = z_end[23] ? 21'd0 : z_end[20:0];
    assign k1    = $signed(k12_reg[15:0]);
    assign k2    = $signed(k12_reg[31:16]);
    assign k3    = $signed(k34_reg[15:0]);
    assign k4    = $signed(k34_reg[31:16]);

    // Side band carried through the polynomial stages: {a, b}, r
    logic [47:0] t0_ab_reg, t1_ab_reg, t2_ab_reg, t3_ab_reg;
    logic [47:0] t4_ab_reg, t5_ab_reg, t6_ab_reg, t7_ab_reg;
    logic [23:0] t0_r_reg, t1_r_reg, t2_r_reg, t3_r_reg;
    logic [23:0] t4_r_reg, t5_r_reg, t6_r_reg, t7_r_reg;
    logic [20:0] t0_th_reg, t1_th_reg, t2_th_reg, t3_th_reg, t4_th_reg, t5_th_reg;
    logic        t0_v_reg, t1_v_reg, t2_v_reg, t3_v_reg;
    logic        t4_v_reg, t5_v_reg, t6_v_reg, t7_v_reg;

    logic [41:0]        t0_sq1_reg;
    logic [21:0]        t1_t2_reg, t2_t2_reg;
    logic [43:0]        t1_sq2_reg;
    logic [23:0]        t2_t4_reg;
    logic [45:0]        t2_t6p_reg;
    logic [47:0]        t2_t8p_reg;
    logic signed [47:0] t3_p1_reg, t3_p2_reg, t3_p3_reg, t3_p4_reg;
    logic signed [47:0] t4_s01_reg, t4_s23_reg;
    logic signed [47:0] t5_acc_reg;
    logic signed [55:0] t6_prod_reg;
    logic [55:0]        t7_num_reg;
    logic               t7_neg_reg;

    logic [21:0]        t2_w;
    logic [23:0]        t4_w;
    logic [25:0]        t6_w;
    logic [27:0]        t8_w;
    logic signed [33:0] poly;
    logic signed [35:0] thd;
    logic [35:0]        thd_mag;

    assign t2_w    = t0_sq1_reg[41:20];
    assign t4_w    = t1_sq2_reg[43:20];
    assign t6_w    = t2_t6p_reg[45:20];
    assign t8_w    = t2_t8p_reg[47:20];
    assign poly    = $signed(t5_acc_reg[47:14]);
    assign thd     = $signed(t6_prod_reg[55:20]);
    assign thd_mag = thd[35] ? 36'(-thd) : 36'(thd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_v_reg <= 1'b0;
            t1_v_reg <= 1'b0;
            t2_v_reg <= 1'b0;
            t3_v_reg <= 1'b0;
            t4_v_reg <= 1'b0;
            t5_v_reg <= 1'b0;
            t6_v_reg <= 1'b0;
            t7_v_reg <= 1'b0;
        end
        else if (en)
        begin
            t0_v_reg <= cv_reg[CSTEPS-1];
            t1_v_reg <= t0_v_reg;
            t2_v_reg <= t1_v_reg;
            t3_v_reg <= t2_v_reg;
            t4_v_reg <= t3_v_reg;
            t5_v_reg <= t4_v_reg;
            t6_v_reg <= t5_v_reg;
            t7_v_reg <= t6_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Clamp theta and square it
            t0_th_reg  <= th;
            t0_sq1_reg <= 42'(th) * 42'(th);
            t0_ab_reg  <= cab_reg[CSTEPS-1];
            t0_r_reg   <= cr_reg[CSTEPS-1];
            // theta^4
            t1_th_reg  <= t0_th_reg;
            t1_t2_reg  <= t2_w;
            t1_sq2_reg <= 44'(t2_w) * 44'(t2_w);
            t1_ab_reg  <= t0_ab_reg;
            t1_r_reg   <= t0_r_reg;
            // theta^6 and theta^8
            t2_th_reg  <= t1_th_reg;
            t2_t2_reg  <= t1_t2_reg;
            t2_t4_reg  <= t4_w;
            t2_t6p_reg <= 46'(t4_w) * 46'(t1_t2_reg);
            t2_t8p_reg <= 48'(t4_w) * 48'(t4_w);
            t2_ab_reg  <= t1_ab_reg;
            t2_r_reg   <= t1_r_reg;
            // Coefficient products
            t3_th_reg  <= t2_th_reg;
            t3_p1_reg  <= 48'(k1) * 48'($signed({1'b0, t2_t2_reg}));
            t3_p2_reg  <= 48'(k2) * 48'($signed({1'b0, t2_t4_reg}));
            t3_p3_reg  <= 48'(k3) * 48'($signed({1'b0, t6_w}));
            t3_p4_reg  <= 48'(k4) * 48'($signed({1'b0, t8_w}));
            t3_ab_reg  <= t2_ab_reg;
            t3_r_reg   <= t2_r_reg;
            // Partial sums, with the constant one in Q.34
            t4_th_reg  <= t3_th_reg;
            t4_s01_reg <= 48'sd17179869184 + t3_p1_reg + t3_p2_reg;
            t4_s23_reg <= t3_p3_reg + t3_p4_reg;
            t4_ab_reg  <= t3_ab_reg;
            t4_r_reg   <= t3_r_reg;
            // Full sum
            t5_th_reg  <= t4_th_reg;
            t5_acc_reg <= t4_s01_reg + t4_s23_reg;
            t5_ab_reg  <= t4_ab_reg;
            t5_r_reg   <= t4_r_reg;
            // theta times polynomial
            t6_prod_reg <= 56'($signed({1'b0, t5_th_reg})) * 56'(poly);
            t6_ab_reg   <= t5_ab_reg;
            t6_r_reg    <= t5_r_reg;
            // Split theta_d into sign and shifted magnitude for the divider
            t7_neg_reg <= thd[35];
            t7_num_reg <= {thd_mag[35:0], 20'd0};
            t7_ab_reg  <= t6_ab_reg;
            t7_r_reg   <= t6_r_reg;
        end
    end

    // ------------------------------------------------------------------
    // Scale = theta_d * 2^20 / r
    // ------------------------------------------------------------------
    logic        dv_v;
    logic [25:0] dv_q;
    logic [49:0] dv_side;
    logic        t7_small;

    assign t7_small = (t7_r_reg < 24'(fud_pkg::R_MIN_Q20));

    fud_div #(
        .SIDE_W (50)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (t7_v_reg),
        .dividend  (t7_num_reg),
        .divisor   (t7_r_reg),
        .side_in   ({t7_ab_reg, t7_small, t7_neg_reg}),
        .out_valid (dv_v),
        .quotient  (dv_q),
        .side_out  (dv_side)
    );

    // ------------------------------------------------------------------
    // Reprojection
    // ------------------------------------------------------------------
    logic signed [23:0] dv_a, dv_b;
    logic signed [26:0] scale;

    assign dv_a  = $signed(dv_side[49:26]);
    assign dv_b  = $signed(dv_side[25:2]);
    assign scale = dv_side[1] ? 27'sd1048576
                 : (dv_side[0] ? -$signed({1'b0, dv_q}) : $signed({1'b0, dv_q}));

    logic               r1_v_reg, r2_v_reg;
    logic signed [50:0] r1_ua_reg, r1_vb_reg;
    logic signed [51:0] r2_px_reg, r2_py_reg;
    logic signed [30:0] u_w, v_w;
    logic signed [52:0] p_x, p_y, adj_x, adj_y;
    logic signed [15:0] sx, sy;
    fud_pkg::out_req_t  out_reg;

    assign u_w   = $signed(r1_ua_reg[50:20]);
    assign v_w   = $signed(r1_vb_reg[50:20]);
    assign p_x   = 53'(r2_px_reg) + 53'($signed({1'b0, centre_x_reg, 20'd0}));
    assign p_y   = 53'(r2_py_reg) + 53'($signed({1'b0, centre_y_reg, 20'd0}));
    // Bias negatives so the shift truncates toward zero
    assign adj_x = p_x[52] ? p_x + 53'sd268435455 : p_x;
    assign adj_y = p_y[52] ? p_y + 53'sd268435455 : p_y;
    assign sx    = sat16($signed(adj_x[52:28]));
    assign sy    = sat16($signed(adj_y[52:28]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_v_reg      <= 1'b0;
            r2_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            r1_v_reg      <= dv_v;
            r2_v_reg      <= r1_v_reg;
            out_valid_reg <= r2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_ua_reg <= 51'(dv_a) * 51'(scale);
            r1_vb_reg <= 51'(dv_b) * 51'(scale);
            r2_px_reg <= 52'($signed({1'b0, focal_x_reg})) * 52'(u_w);
            r2_py_reg <= 52'($signed({1'b0, focal_y_reg})) * 52'(v_w);
            out_reg.src_x    <= sx;
            out_reg.src_y    <= sy;
            out_reg.in_range <= !sx[15] && (int'(sx) < IMG_WIDTH)
                             && !sy[15] && (int'(sy) < IMG_HEIGHT);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_v_reg)
        else $error("accepted request did not enter the pipeline");

    a_theta: assert property (@(posedge clk) disable iff (!rst_n)
        t0_v_reg |-> (t0_th_reg <= TH_MAX))
        else $error("theta beyond the CORDIC angle range");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(r2_v_reg) && $stable(t7_v_reg) && $stable(s4_v_reg)))
        else $error("pipeline moved during a stall");

endmodule

// ----- tb/fisheye_undistort_map_tb.sv -----
// ----------------------------------------------------------------------------
// fisheye_undistort_map_tb
// Drives output pixel coordinates through the fisheye mapper under random
// bursts and output stalls, predicts each source coordinate in fixed point
// and checks every returned request in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fisheye_undistort_map_tb;

    localparam int  IMG_W      = 1024;
    localparam int  IMG_H      = 1024;
    localparam int  LATENCY    = 89;
    localparam int  HOLD_LEN   = 400;
    localparam longint CYCLE_LIMIT = 600000;

    // atan(2^-i) in Q.20
    localparam longint ANGLE_STEP [24] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 1, 0, 0
    };

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    fud_pkg::in_req_t  in_data;
    logic              out_valid;
    logic              out_ready;
    fud_pkg::out_req_t out_data;
    logic              cfg_write;
    logic [2:0]        cfg_index;
    logic [31:0]       cfg_data;

    // Camera settings as last written
    logic [19:0] cam_fx, cam_fy, cam_cx, cam_cy;
    logic [23:0] cam_inv_x, cam_inv_y;
    logic [31:0] cam_k12, cam_k34;

    fud_pkg::out_req_t expected_src[$];
    int       mismatches;
    longint   cycles;
    int       burst_left;
    int       hold_req;
    int       hold_seen;
    int       hold_cnt;
    bit       ready_phase;
    int       phase_left;

    fisheye_undistort_map #(
        .IMG_WIDTH  (IMG_W),
        .IMG_HEIGHT (IMG_H)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Back-project one axis into Q4.20 and saturate
    function automatic longint back_project_axis(logic [11:0] pix, logic [19:0] c,
                                                 logic [23:0] inv);
        longint d;
        longint p;
        d = longint'(pix) * 256 - longint'(c);
        p = (d * longint'(inv)) >>> 12;
        if (p < -(longint'(1) << 23))
            p = -(longint'(1) << 23);
        else if (p > (longint'(1) << 23) - 1)
            p = (longint'(1) << 23) - 1;
        return p;
    endfunction

    // Scale an offset and reproject to a saturated pixel coordinate
    function automatic logic signed [15:0] reproject_axis(longint off, longint scale,
                                                          logic [19:0] f, logic [19:0] c);
        longint u;
        longint p;
        longint q;
        u = (off * scale) >>> 20;
        p = longint'(f) * u + longint'(c) * (longint'(1) << 20);
        q = p / (longint'(1) << 28);
        if (q < -32768)
            q = -32768;
        else if (q > 32767)
            q = 32767;
        return q[15:0];
    endfunction

    // Work out the source pixel for one output pixel
    function automatic fud_pkg::out_req_t predict_source(logic [11:0] px, logic [11:0] py);
        longint a, b, r, scale, th, t2, t4, t6, t8, acc, poly, thd;
        longint cx, cy, cz, nx;
        longint unsigned n, root, bitv;
        fud_pkg::out_req_t res;
        a = back_project_axis(px, cam_cx, cam_inv_x);
        b = back_project_axis(py, cam_cy, cam_inv_y);
        // integer square root of the squared radius
        n = longint'(a * a) + longint'(b * b);
        root = 0;
        bitv = longint'(1) << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        r = longint'(root);
        if (r < fud_pkg::R_MIN_Q20)
            scale = longint'(1) << 20;
        else
        begin
            // atan by CORDIC vectoring
            cx = longint'(1) << 28;
            cy = r * 256;
            cz = 0;
            for (int i = 0; i < 24; i++)
            begin
                if (cy > 0)
                begin
                    nx = cx + (cy >>> i);
                    cy = cy - (cx >>> i);
                    cz = cz + ANGLE_STEP[i];
                end
                else
                begin
                    nx = cx - (cy >>> i);
                    cy = cy + (cx >>> i);
                    cz = cz - ANGLE_STEP[i];
                end
                cx = nx;
            end
            th = (cz < 0) ? 0 : cz;
            t2 = (th * th) >>> 20;
            t4 = (t2 * t2) >>> 20;
            t6 = (t4 * t2) >>> 20;
            t8 = (t4 * t4) >>> 20;
            acc = (longint'(1) << 34)
                + longint'($signed(cam_k12[15:0])) * t2
                + longint'($signed(cam_k12[31:16])) * t4
                + longint'($signed(cam_k34[15:0])) * t6
                + longint'($signed(cam_k34[31:16])) * t8;
            poly = acc >>> 14;
            thd = (th * poly) >>> 20;
            scale = (thd * (longint'(1) << 20)) / r;
        end
        res.src_x = reproject_axis(a, scale, cam_fx, cam_cx);
        res.src_y = reproject_axis(b, scale, cam_fy, cam_cy);
        res.in_range = (res.src_x >= 0) && (res.src_x < IMG_W)
                    && (res.src_y >= 0) && (res.src_y < IMG_H);
        return res;
    endfunction

    // Send one request, with random gaps between bursts
    task automatic send_pixel(input logic [11:0] px, input logic [11:0] py);
        int gap;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        in_valid <= 1'b1;
        in_data.out_x <= px;
        in_data.out_y <= py;
        do
            @(posedge clk);
        while (!in_ready);
        expected_src.push_back(predict_source(px, py));
        burst_left--;
    endtask

    // Wait until every expected request has come back and the pipe is empty
    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_src.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // Write all eight camera registers, block idle
    task automatic load_camera(input logic [19:0] fx, input logic [19:0] fy,
                               input logic [19:0] cx, input logic [19:0] cy,
                               input logic [23:0] ix, input logic [23:0] iy,
                               input logic [31:0] k12, input logic [31:0] k34);
        logic [31:0] vals [8];
        vals = '{32'(fx), 32'(fy), 32'(cx), 32'(cy), 32'(ix), 32'(iy), k12, k34};
        for (int i = 0; i < 8; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= fud_pkg::reg_idx_t'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        cam_fx = fx;
        cam_fy = fy;
        cam_cx = cx;
        cam_cy = cy;
        cam_inv_x = ix;
        cam_inv_y = iy;
        cam_k12 = k12;
        cam_k34 = k34;
    endtask

    task automatic load_typical_camera();
        load_camera(20'd128000, 20'd128000, 20'd131072, 20'd131072,
                    24'd33554, 24'd33554, 32'h0031_FEB8, 32'h0001_FFF8);
    endtask

    task automatic send_random_pixels(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(12'($urandom), 12'($urandom));
    endtask

    // Registers at reset: every pixel maps to the origin
    task automatic test_reset_defaults();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd1234, 12'd77);
        wait_idle();
    endtask

    // Corners, the principal point and saturated offsets
    task automatic test_directed();
        load_typical_camera();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd512, 12'd512);
        send_pixel(12'd513, 12'd512);
        send_pixel(12'd512, 12'd511);
        send_pixel(12'd1023, 12'd1023);
        send_pixel(12'd1024, 12'd0);
        send_pixel(12'd2730, 12'd1365);
        wait_idle();
        // huge reciprocals drive the offsets into saturation
        load_camera(20'hFFFFF, 20'hFFFFF, 20'd131072, 20'd131072,
                    24'hFFFFFF, 24'hFFFFFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd512, 12'd512);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd600, 12'd300);
        wait_idle();
    endtask

    // Extremes of every register
    task automatic test_register_extremes();
        load_camera(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
                    24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_random_pixels(60);
        wait_idle();
        load_camera(20'hFFFFF, 20'h0, 20'h0, 20'hFFFFF,
                    24'h1, 24'h800000, 32'h8000_8000, 32'h8000_8000);
        send_random_pixels(60);
        wait_idle();
    endtask

    // Random pixels over several camera settings
    task automatic test_random_cameras();
        load_typical_camera();
        send_random_pixels(400);
        wait_idle();
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase % 2 == 0)
                // plausible lenses: modest reciprocals, small distortion terms
                load_camera(20'($urandom_range(25600, 400000)),
                            20'($urandom_range(25600, 400000)),
                            20'($urandom_range(0, 1048575)),
                            20'($urandom_range(0, 1048575)),
                            24'($urandom_range(4000, 300000)),
                            24'($urandom_range(4000, 300000)),
                            {16'($signed(12'($urandom))), 16'($signed(12'($urandom)))},
                            {16'($signed(10'($urandom))), 16'($signed(10'($urandom)))});
            else
                load_camera(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
                            24'($urandom), 24'($urandom), $urandom, $urandom);
            send_random_pixels(135);
            wait_idle();
        end
    endtask

    // Hold the output off long enough to fill the pipe and stall the input
    task automatic test_output_backpressure();
        load_typical_camera();
        hold_req++;
        send_random_pixels(250);
        wait_idle();
    endtask

    // Output stall pattern, with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_cnt > 0)
        begin
            out_ready <= 1'b0;
            hold_cnt--;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_cnt = HOLD_LEN;
            out_ready <= 1'b0;
        end
        else
        begin
            if (phase_left <= 0)
            begin
                ready_phase = !ready_phase;
                phase_left = ready_phase ? $urandom_range(1, 60) : $urandom_range(1, 6);
            end
            out_ready <= ready_phase;
            phase_left--;
        end
    end

    // Check each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        fud_pkg::out_req_t exp_src;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_src.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, out_data);
                mismatches++;
            end
            else
            begin
                exp_src = expected_src.pop_front();
                if (out_data.src_x !== exp_src.src_x)
                begin
                    $display("%0t: src_x expected %0d actual %0d", $realtime,
                             exp_src.src_x, out_data.src_x);
                    mismatches++;
                end
                if (out_data.src_y !== exp_src.src_y)
                begin
                    $display("%0t: src_y expected %0d actual %0d", $realtime,
                             exp_src.src_y, out_data.src_y);
                    mismatches++;
                end
                if (out_data.in_range !== exp_src.in_range)
                begin
                    $display("%0t: in_range expected %0b actual %0b", $realtime,
                             exp_src.in_range, out_data.in_range);
                    mismatches++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_write = 1'b0;
        cfg_index = fud_pkg::REG_FOCAL_X;
        cfg_data = '0;
        cam_fx = '0;
        cam_fy = '0;
        cam_cx = '0;
        cam_cy = '0;
        cam_inv_x = '0;
        cam_inv_y = '0;
        cam_k12 = '0;
        cam_k34 = '0;
        mismatches = 0;
        cycles = 0;
        burst_left = 0;
        hold_req = 0;
        hold_seen = 0;
        hold_cnt = 0;
        ready_phase = 1'b0;
        phase_left = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed();
        test_register_extremes();
        test_output_backpressure();
        test_random_cameras();
        test_output_backpressure();

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
